[src/hufd_pkg.sv]
// hufd_pkg: shared types and constants for the Huffman tree build and decode block.
// Used by the controller, the datapath, the top level and the port checker.
`timescale 1ns / 1ps
package hufd_pkg;

    localparam int SYMBOLS_DEF     = 256;
    localparam int COUNT_WIDTH_DEF = 31;

    localparam int SYM_W     = 8;
    localparam int CNT_IN_W  = 31;
    localparam int BITS_W    = 4;
    localparam int IN_DATA_W = 56;

    // input tdata field offsets, lowest bit up
    localparam int OFS_SYM   = 0;
    localparam int OFS_CNT   = OFS_SYM + SYM_W;
    localparam int OFS_BYTE  = OFS_CNT + CNT_IN_W;
    localparam int OFS_BITS  = OFS_BYTE + 8;

    localparam logic [BITS_W-1:0] MAX_BITS = 4'd8;

    localparam logic REQ_COUNT = 1'b0;
    localparam logic REQ_DATA  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_MERGE,
        ST_ROOT,
        ST_DEC,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic cnt_wr;
        logic build_start;
        logic ld_issue;
        logic fin_empty;
        logic fin_single;
        logic merge_init;
        logic scan_start;
        logic sc_issue;
        logic merge;
        logic root_rd;
        logic byte_load;
        logic step;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic ld_pend;
        logic sc_pend;
        logic idx_at_n;
        logic n_zero;
        logic n_one;
        logic live_two;
        logic tree_ready;
        logic emit;
        logic pend_v;
        logic out_free;
    } t_sts;

endpackage

[src/hufd_ctrl.sv]
// hufd_ctrl: sequencer for count loading, tree build rounds and bit-serial decode.
// Depends on hufd_pkg; drives the datapath through t_cmd and reads t_sts.
`timescale 1ns / 1ps
module hufd_ctrl import hufd_pkg::*; #(
    parameter int SYMBOLS = SYMBOLS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_acc,
    input  logic                                 i_req_type,
    input  logic                                 i_last,
    input  logic [BITS_W-1:0]                    i_bits_used,
    input  t_sts                                 i_sts,
    output logic                                 o_ready,
    output logic [$clog2(2*SYMBOLS-1)-1:0]       o_idx,
    output t_cmd                                 o_cmd
);

    localparam int NDW = $clog2(2*SYMBOLS-1);

    t_state            r_state, n_state;
    logic [NDW-1:0]    r_idx, n_idx;
    logic [BITS_W-1:0] r_bits, n_bits;
    logic              step_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_bits  <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_bits  <= n_bits;
        end
    end

    assign step_ok = !(i_sts.emit && i_sts.pend_v && !i_sts.out_free);
    assign o_idx   = r_idx;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_bits  = r_bits;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_acc) begin
                    if (i_req_type == REQ_COUNT) begin
                        o_cmd.cnt_wr = 1'b1;
                        if (i_last) begin
                            o_cmd.build_start = 1'b1;
                            n_idx   = '0;
                            n_state = ST_LOAD;
                        end
                    end else if (i_sts.tree_ready && i_bits_used != '0) begin
                        o_cmd.byte_load = 1'b1;
                        n_bits  = (i_bits_used > MAX_BITS) ? MAX_BITS : i_bits_used;
                        n_state = ST_DEC;
                    end
                end
            end
            ST_LOAD: begin
                if (r_idx != NDW'(SYMBOLS)) begin
                    o_cmd.ld_issue = 1'b1;
                    n_idx = r_idx + 1'b1;
                end else if (!i_sts.ld_pend) begin
                    if (i_sts.n_zero) begin
                        o_cmd.fin_empty = 1'b1;
                        n_state = ST_IDLE;
                    end else if (i_sts.n_one) begin
                        o_cmd.fin_single = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.merge_init = 1'b1;
                        o_cmd.scan_start = 1'b1;
                        n_idx   = '0;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (!i_sts.idx_at_n) begin
                    o_cmd.sc_issue = 1'b1;
                    n_idx = r_idx + 1'b1;
                end else if (!i_sts.sc_pend) begin
                    n_state = ST_MERGE;
                end
            end
            ST_MERGE: begin
                o_cmd.merge = 1'b1;
                if (i_sts.live_two) begin
                    n_state = ST_ROOT;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_idx   = '0;
                    n_state = ST_SCAN;
                end
            end
            ST_ROOT: begin
                o_cmd.root_rd = 1'b1;
                n_state = ST_IDLE;
            end
            ST_DEC: begin
                if (step_ok) begin
                    o_cmd.step = 1'b1;
                    n_bits = r_bits - 1'b1;
                    if (r_bits == 4'd1) begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (!i_sts.pend_v) begin
                    n_state = ST_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[src/hufd_dp.sv]
// hufd_dp: count store, slot store, node store, candidate registers, walk and output stage.
// Depends on hufd_pkg; steered by hufd_ctrl through t_cmd.
`timescale 1ns / 1ps
module hufd_dp import hufd_pkg::*; #(
    parameter int SYMBOLS     = SYMBOLS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_cmd                            i_cmd,
    input  logic [$clog2(2*SYMBOLS-1)-1:0]  i_idx,
    input  logic [SYM_W-1:0]                i_symbol_code,
    input  logic [CNT_IN_W-1:0]             i_symbol_count,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_m_tready,
    output t_sts                            o_sts,
    output logic                            o_m_tvalid,
    output logic [SYM_W-1:0]                o_symbol,
    output logic                            o_last
);

    localparam int NDW   = $clog2(2*SYMBOLS-1);
    localparam int NODES = 2*SYMBOLS-1;
    localparam int SW    = $clog2(SYMBOLS);
    localparam int WW    = COUNT_WIDTH + 8;

    typedef struct packed {
        logic [NDW-1:0]   zero;
        logic [NDW-1:0]   one;
        logic [SYM_W-1:0] zsym;
        logic [SYM_W-1:0] osym;
    } t_node;

    // count store
    logic [COUNT_WIDTH-1:0] cnt_mem [SYMBOLS];
    logic [SYMBOLS-1:0]     r_cnt_vld;
    logic [COUNT_WIDTH-1:0] r_cnt_q;
    logic                   r_cnt_qv;
    logic                   r_ld_pend;
    logic [SYM_W-1:0]       r_ld_sym;
    logic                   ld_hit;

    // slot store
    logic [WW-1:0]          slot_w    [SYMBOLS];
    logic [NDW-1:0]         slot_node [SYMBOLS];
    logic [SYM_W-1:0]       slot_sym  [SYMBOLS];
    logic [SYMBOLS-1:0]     r_live;
    logic                   slot_we;
    logic [SW-1:0]          slot_wa;
    logic [WW-1:0]          slot_wd_w;
    logic [NDW-1:0]         slot_wd_node;
    logic [SYM_W-1:0]       slot_wd_sym;

    // scan and candidates
    logic                   r_sc_pend;
    logic [SW-1:0]          r_sc_i;
    logic [WW-1:0]          r_sc_w;
    logic [NDW-1:0]         r_sc_node;
    logic [SYM_W-1:0]       r_sc_sym;
    logic                   r_have_a, r_have_b;
    logic [SW-1:0]          r_ia, r_ib;
    logic [WW-1:0]          r_wa, r_wb;
    logic [NDW-1:0]         r_na, r_nb;
    logic [SYM_W-1:0]       r_sa, r_sb;

    // tree bookkeeping
    logic [NDW-1:0]         r_n, r_next, r_live_cnt, r_root;
    logic                   r_ready, r_single;
    logic [SYM_W-1:0]       r_single_sym;

    // node store and walk
    t_node                  node_mem [NODES];
    t_node                  r_cur;
    logic [NDW-1:0]         node_ra;
    logic [NDW-1:0]         child;
    logic [SYM_W-1:0]       child_sym;
    logic                   child_leaf;
    logic                   emit;
    logic [SYM_W-1:0]       emit_sym;
    logic [7:0]             r_byte;

    // output stage
    logic                   r_pend_v;
    logic [SYM_W-1:0]       r_pend_sym;
    logic                   r_o_valid;
    logic [SYM_W-1:0]       r_o_sym;
    logic                   r_o_last;
    logic                   out_free;
    logic                   push;

    assign ld_hit = r_ld_pend && r_cnt_qv && (r_cnt_q != '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.cnt_wr && ({1'b0, i_symbol_code} < 9'(SYMBOLS))) begin
            cnt_mem[i_symbol_code[SW-1:0]] <= COUNT_WIDTH'(i_symbol_count);
        end
        if (i_cmd.ld_issue) begin
            r_cnt_q  <= cnt_mem[i_idx[SW-1:0]];
            r_cnt_qv <= r_cnt_vld[i_idx[SW-1:0]];
            r_ld_sym <= SYM_W'(i_idx[SW-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_vld <= '0;
            r_ld_pend <= 1'b0;
        end else begin
            r_ld_pend <= i_cmd.ld_issue;
            if (i_cmd.cnt_wr && ({1'b0, i_symbol_code} < 9'(SYMBOLS))) begin
                r_cnt_vld[i_symbol_code[SW-1:0]] <= 1'b1;
            end
        end
    end

    // slot store write port: load fills, merge rewrites the first candidate
    always_comb begin
        slot_we      = 1'b0;
        slot_wa      = r_n[SW-1:0];
        slot_wd_w    = WW'(r_cnt_q);
        slot_wd_node = r_n;
        slot_wd_sym  = r_ld_sym;
        if (ld_hit) begin
            slot_we = 1'b1;
        end else if (i_cmd.merge) begin
            slot_we      = 1'b1;
            slot_wa      = r_ia;
            slot_wd_w    = r_wa + r_wb;
            slot_wd_node = r_next;
            slot_wd_sym  = r_sa;
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            slot_w[slot_wa]    <= slot_wd_w;
            slot_node[slot_wa] <= slot_wd_node;
            slot_sym[slot_wa]  <= slot_wd_sym;
        end
        if (i_cmd.sc_issue) begin
            r_sc_i    <= i_idx[SW-1:0];
            r_sc_w    <= slot_w[i_idx[SW-1:0]];
            r_sc_node <= slot_node[i_idx[SW-1:0]];
            r_sc_sym  <= slot_sym[i_idx[SW-1:0]];
        end
    end

    // candidate pick; a tie below the first candidate replaces it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc_pend <= 1'b0;
            r_have_a  <= 1'b0;
            r_have_b  <= 1'b0;
        end else begin
            r_sc_pend <= i_cmd.sc_issue && r_live[i_idx[SW-1:0]];
            if (i_cmd.scan_start) begin
                r_have_a <= 1'b0;
                r_have_b <= 1'b0;
            end else if (r_sc_pend) begin
                if (!r_have_a) begin
                    r_have_a <= 1'b1;
                end else if (!r_have_b) begin
                    r_have_b <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sc_pend) begin
            if (!r_have_a || (r_have_b && r_sc_w < r_wa && !(r_wb > r_wa))) begin
                r_ia <= r_sc_i; r_wa <= r_sc_w; r_na <= r_sc_node; r_sa <= r_sc_sym;
            end else if (!r_have_b || (r_sc_w < r_wa) || (r_sc_w < r_wb)) begin
                r_ib <= r_sc_i; r_wb <= r_sc_w; r_nb <= r_sc_node; r_sb <= r_sc_sym;
            end
        end
    end

    // live bits and tree bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live       <= '0;
            r_n          <= '0;
            r_next       <= '0;
            r_live_cnt   <= '0;
            r_root       <= '0;
            r_ready      <= 1'b0;
            r_single     <= 1'b0;
            r_single_sym <= '0;
        end else begin
            if (i_cmd.build_start) begin
                r_live <= '0;
                r_n    <= '0;
            end else if (ld_hit) begin
                r_live[r_n[SW-1:0]] <= 1'b1;
                r_n <= r_n + 1'b1;
                if (r_n == '0) begin
                    r_single_sym <= r_ld_sym;
                end
            end
            if (i_cmd.fin_empty) begin
                r_ready <= 1'b0;
            end
            if (i_cmd.fin_single) begin
                r_ready  <= 1'b1;
                r_single <= 1'b1;
            end
            if (i_cmd.merge_init) begin
                r_next     <= r_n;
                r_live_cnt <= r_n;
            end
            if (i_cmd.merge) begin
                r_live[r_ib] <= 1'b0;
                r_next       <= r_next + 1'b1;
                r_live_cnt   <= r_live_cnt - 1'b1;
            end
            if (i_cmd.root_rd) begin
                r_root   <= r_next - 1'b1;
                r_ready  <= 1'b1;
                r_single <= 1'b0;
            end
        end
    end

    // one code bit: pick the branch, a leaf child emits and returns to the root
    always_comb begin
        child      = r_byte[7] ? r_cur.one : r_cur.zero;
        child_sym  = r_byte[7] ? r_cur.osym : r_cur.zsym;
        child_leaf = child < r_n;
        emit       = r_single || child_leaf;
        emit_sym   = r_single ? r_single_sym : child_sym;
        if (i_cmd.root_rd) begin
            node_ra = r_next - 1'b1;
        end else if (child_leaf) begin
            node_ra = r_root;
        end else begin
            node_ra = child;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.merge) begin
            node_mem[r_next] <= '{zero: r_na, one: r_nb, zsym: r_sa, osym: r_sb};
        end
        if (i_cmd.root_rd || (i_cmd.step && !r_single)) begin
            r_cur <= node_mem[node_ra];
        end
        if (i_cmd.byte_load) begin
            r_byte <= i_data_byte;
        end else if (i_cmd.step) begin
            r_byte <= {r_byte[6:0], 1'b0};
        end
    end

    // hold the newest symbol back until it is known whether it ends the byte
    assign out_free = !r_o_valid || i_m_tready;
    assign push     = (i_cmd.step && emit && r_pend_v) || i_cmd.flush;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.flush) begin
                r_pend_v <= 1'b0;
            end else if (i_cmd.step && emit) begin
                r_pend_v <= 1'b1;
            end
            if (push) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && emit) begin
            r_pend_sym <= emit_sym;
        end
        if (push) begin
            r_o_sym  <= r_pend_sym;
            r_o_last <= i_cmd.flush;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_symbol   = r_o_sym;
    assign o_last     = r_o_last;

    always_comb begin
        o_sts            = '0;
        o_sts.ld_pend    = r_ld_pend;
        o_sts.sc_pend    = r_sc_pend;
        o_sts.idx_at_n   = (i_idx == r_n);
        o_sts.n_zero     = (r_n == '0);
        o_sts.n_one      = (r_n == NDW'(1));
        o_sts.live_two   = (r_live_cnt == NDW'(2));
        o_sts.tree_ready = r_ready;
        o_sts.emit       = emit;
        o_sts.pend_v     = r_pend_v;
        o_sts.out_free   = out_free;
    end

endmodule

[src/huffman_tree_build_and_decode_top.sv]
// Channel | dir | tdata (low bit up)                                    | tlast      | tuser
// s       | in  | symbol_code 8, symbol_count 31, data_byte 8,          | last_count | req_type
//         |     | bits_used 4, zero pad to 56                           |            |
// m       | out | decoded_symbol 8                                      | last_of_run| -
//
// A count beat other than the last leaves the block idle and ready. The last count beat
// starts a build: one pass over the count store, then for n present symbols n-1 merge
// rounds, each a scan of the slot store through its single read port.
// A data byte is accepted, then walked one tree level per used bit (node store read),
// then its last symbol is released; output stalls hold the walk.
// Reset is synchronous active low and clears all counts; no clearing pass is needed.
// Depends on hufd_pkg, hufd_ctrl and hufd_dp.
`timescale 1ns / 1ps
module huffman_tree_build_and_decode_top import hufd_pkg::*; #(
    parameter int SYMBOLS     = SYMBOLS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,  // symbol_code, symbol_count, data_byte, bits_used
    input  logic                  i_s_tlast,
    input  logic                  i_s_tuser,  // req_type
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [SYM_W-1:0]      o_m_tdata,  // decoded_symbol
    output logic                  o_m_tlast
);

    localparam int NDW = $clog2(2*SYMBOLS-1);

    t_cmd           cmd;
    t_sts           sts;
    logic [NDW-1:0] idx;
    logic           acc;

    assign acc = i_s_tvalid && o_s_tready;

    hufd_ctrl #(
        .SYMBOLS (SYMBOLS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (acc),
        .i_req_type  (i_s_tuser),
        .i_last      (i_s_tlast),
        .i_bits_used (i_s_tdata[OFS_BITS +: BITS_W]),
        .i_sts       (sts),
        .o_ready     (o_s_tready),
        .o_idx       (idx),
        .o_cmd       (cmd)
    );

    hufd_dp #(
        .SYMBOLS     (SYMBOLS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_idx          (idx),
        .i_symbol_code  (i_s_tdata[OFS_SYM +: SYM_W]),
        .i_symbol_count (i_s_tdata[OFS_CNT +: CNT_IN_W]),
        .i_data_byte    (i_s_tdata[OFS_BYTE +: 8]),
        .i_m_tready     (i_m_tready),
        .o_sts          (sts),
        .o_m_tvalid     (o_m_tvalid),
        .o_symbol       (o_m_tdata),
        .o_last         (o_m_tlast)
    );

endmodule

[src/hufd_chk.sv]
// hufd_chk: port-level checks for the Huffman build and decode top level.
// Depends on hufd_pkg; bound to huffman_tree_build_and_decode_top below.
`timescale 1ns / 1ps
module hufd_chk import hufd_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_tvalid,
    input logic                 o_s_tready,
    input logic [IN_DATA_W-1:0] i_s_tdata,
    input logic                 i_s_tlast,
    input logic                 i_s_tuser,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [SYM_W-1:0]     o_m_tdata,
    input logic                 o_m_tlast
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("result beat changed under stall");

    // the final count beat starts a build, so input closes
    a_build_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser == REQ_COUNT && i_s_tlast |=> !o_s_tready)
        else $error("input open right after build start");

    // a plain count beat leaves the input open in the cycle after it
    a_count_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser == REQ_COUNT && !i_s_tlast |=> o_s_tready)
        else $error("count beat stalled input");

    // a data byte with no used bits leaves the block idle
    a_empty_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser == REQ_DATA
        && i_s_tdata[OFS_BITS +: BITS_W] == '0 |=> o_s_tready)
        else $error("empty byte stalled input");

endmodule

bind huffman_tree_build_and_decode_top hufd_chk u_hufd_chk (.*);

[verif/hufd_decode_checker.sv]
// hufd_decode_checker: watches both stream channels of the Huffman decoder, rebuilds
// the code tree from the accepted count beats and checks every decoded symbol.
// Depends on hufd_pkg for field offsets and request codes.
`timescale 1ns / 1ps
module hufd_decode_checker import hufd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [IN_DATA_W-1:0] i_s_tdata,  // symbol_code, symbol_count, data_byte, bits_used
    input  logic                 i_s_tlast,
    input  logic                 i_s_tuser,  // req_type
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [SYM_W-1:0]     i_m_tdata,  // decoded_symbol
    input  logic                 i_m_tlast,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam int NSYM  = 256;
    localparam int NNODE = 2 * NSYM - 1;
    localparam logic [8:0] INNER = 9'd256;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
    } t_sym_beat;

    t_sym_beat        pending_symbols[$];
    logic [30:0]      sym_count[NSYM];
    logic [38:0]      slot_wt[NSYM];
    logic [8:0]       slot_nd[NSYM];
    logic             slot_on[NSYM];
    logic [8:0]       zero_kid[NNODE];
    logic [8:0]       one_kid[NNODE];
    logic [8:0]       leaf_sym[NNODE];
    logic [8:0]       root_nd;
    logic [8:0]       walk_nd;
    logic             have_tree;

    assign o_pending = pending_symbols.size();

    function automatic void build_code_tree();
        int n, nxt, live, ia, ib;
        logic ha, hb;
        logic [38:0] wa, wb, w;
        n = 0;
        for (int s = 0; s < NSYM; s++) begin
            if (sym_count[s] != 0) begin
                slot_wt[n]  = 39'(sym_count[s]);
                slot_nd[n]  = 9'(n);
                slot_on[n]  = 1'b1;
                leaf_sym[n] = 9'(s);
                zero_kid[n] = '0;
                one_kid[n]  = '0;
                n++;
            end
        end
        for (int s = n; s < NSYM; s++) slot_on[s] = 1'b0;
        if (n == 0) begin
            have_tree = 1'b0;
            root_nd   = '0;
            walk_nd   = '0;
            return;
        end
        nxt  = n;
        live = n;
        while (live > 1 && nxt < NNODE) begin
            ha = 0; hb = 0; ia = 0; ib = 0; wa = '0; wb = '0;
            for (int i = 0; i < n; i++) begin
                if (!slot_on[i]) continue;
                w = slot_wt[i];
                if (!ha) begin ha = 1; wa = w; ia = i; end
                else if (!hb) begin hb = 1; wb = w; ib = i; end
                else if (w < wa) begin
                    // a tie between the candidates drops the first one
                    if (wb > wa) begin wb = w; ib = i; end
                    else begin wa = w; ia = i; end
                end else if (w < wb) begin
                    wb = w; ib = i;
                end
            end
            zero_kid[nxt] = slot_nd[ia];
            one_kid[nxt]  = slot_nd[ib];
            leaf_sym[nxt] = INNER;
            slot_wt[ia]   = wa + wb;
            slot_nd[ia]   = 9'(nxt);
            slot_on[ib]   = 1'b0;
            nxt++;
            live--;
        end
        root_nd   = slot_nd[0];
        walk_nd   = root_nd;
        have_tree = 1'b1;
    endfunction

    function automatic logic is_leaf(logic [8:0] nd);
        return (nd < NNODE) && (leaf_sym[nd] != INNER);
    endfunction

    function automatic void decode_byte(logic [7:0] code, logic [3:0] used);
        int nbits, first;
        logic b;
        if (!have_tree) return;
        nbits = (used > 8) ? 8 : int'(used);
        first = pending_symbols.size();
        for (int j = 0; j < nbits; j++) begin
            b = code[7-j];
            if (walk_nd >= NNODE) walk_nd = root_nd;
            if (is_leaf(walk_nd)) begin
                // single-symbol tree: every bit emits the root
                pending_symbols.push_back('{leaf_sym[walk_nd][7:0], 1'b0});
                walk_nd = root_nd;
            end else begin
                walk_nd = b ? one_kid[walk_nd] : zero_kid[walk_nd];
                if (is_leaf(walk_nd)) begin
                    pending_symbols.push_back('{leaf_sym[walk_nd][7:0], 1'b0});
                    walk_nd = root_nd;
                end
            end
        end
        if (pending_symbols.size() > first)
            pending_symbols[pending_symbols.size()-1].last = 1'b1;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NSYM; s++) begin
                sym_count[s] = '0;
                slot_on[s]   = 1'b0;
            end
            root_nd      = '0;
            walk_nd      = '0;
            have_tree    = 1'b0;
            o_fail_count = 0;
            pending_symbols.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (pending_symbols.size() == 0) begin
                    $error("unexpected output beat: decoded_symbol %0d", i_m_tdata);
                    o_fail_count++;
                end else begin
                    if (i_m_tdata !== pending_symbols[0].symbol) begin
                        $error("decoded_symbol exp %0d got %0d",
                               pending_symbols[0].symbol, i_m_tdata);
                        o_fail_count++;
                    end
                    if (i_m_tlast !== pending_symbols[0].last) begin
                        $error("last_of_run exp %0d got %0d",
                               pending_symbols[0].last, i_m_tlast);
                        o_fail_count++;
                    end
                    void'(pending_symbols.pop_front());
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == REQ_COUNT) begin
                    sym_count[i_s_tdata[OFS_SYM +: SYM_W]] = i_s_tdata[OFS_CNT +: CNT_IN_W];
                    if (i_s_tlast) build_code_tree();
                end else begin
                    decode_byte(i_s_tdata[OFS_BYTE +: 8], i_s_tdata[OFS_BITS +: BITS_W]);
                end
            end
        end
    end

endmodule

[verif/tb_huffman_tree_build_and_decode_top.sv]
// tb_huffman_tree_build_and_decode_top: drives count and data beats into the decoder
// with random gaps and output stalls; hufd_decode_checker predicts and compares.
// Depends on hufd_pkg, huffman_tree_build_and_decode_top and hufd_decode_checker.
`timescale 1ns / 1ps
module tb_huffman_tree_build_and_decode_top;
    import hufd_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [IN_DATA_W-1:0] i_s_tdata;  // symbol_code, symbol_count, data_byte, bits_used
    logic                 i_s_tlast;
    logic                 i_s_tuser;  // req_type
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [SYM_W-1:0]     o_m_tdata;  // decoded_symbol
    logic                 o_m_tlast;

    int   fail_count;
    int   pending;
    int   cycles;
    int   sent;
    bit   long_hold;
    bit   in_use[256];

    huffman_tree_build_and_decode_top dut (.*);

    hufd_decode_checker u_checker (
        .i_clk, .i_rst_n,
        .i_s_tvalid, .i_s_tready(o_s_tready), .i_s_tdata, .i_s_tlast, .i_s_tuser,
        .i_m_tvalid(o_m_tvalid), .i_m_tready, .i_m_tdata(o_m_tdata), .i_m_tlast(o_m_tlast),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[huffman_tree_build_and_decode_top] ERROR");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(3, 1);
        if (r < 98) return $urandom_range(12, 4);
        return $urandom_range(80, 30);
    endfunction

    // receiver: random stalls, one long hold-off on request
    initial begin
        int g;
        bit hold_done;
        hold_done = 0;
        i_m_tready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_hold && !hold_done) begin
                i_m_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_done = 1;
            end
            g = pick_gap();
            if (g > 0) begin
                i_m_tready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            repeat ($urandom_range(20, 1)) @(posedge i_clk);
        end
    end

    task automatic send_beat(logic req, logic [7:0] sym, logic [30:0] cnt, logic lst,
                             logic [7:0] code, logic [3:0] used);
        logic [IN_DATA_W-1:0] d;
        int g;
        d = '0;
        d[OFS_SYM +: SYM_W]     = sym;
        d[OFS_CNT +: CNT_IN_W]  = cnt;
        d[OFS_BYTE +: 8]        = code;
        d[OFS_BITS +: BITS_W]   = used;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= d;
        i_s_tlast  <= lst;
        i_s_tuser  <= req;
        do @(posedge i_clk); while (!o_s_tready);
        sent++;
        g = pick_gap();
        if (g > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic send_count(logic [7:0] sym, logic [30:0] cnt, logic lst);
        in_use[sym] = (cnt != 0);
        send_beat(REQ_COUNT, sym, cnt, lst, 8'($urandom), 4'($urandom));
    endtask

    task automatic send_byte(logic [7:0] code, logic [3:0] used);
        send_beat(REQ_DATA, 8'($urandom), 31'($urandom), 1'($urandom), code, used);
    endtask

    // let the checker take in the last beat before polling its queue
    task automatic wait_drained();
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [30:0] rand_count();
        int r;
        r = $urandom_range(9);
        if (r < 5) return 31'($urandom_range(20, 1));
        if (r < 8) return 31'($urandom_range(5000, 1));
        return 31'($urandom_range(32'h7FFF_FFFF, 1));
    endfunction

    function automatic logic [3:0] rand_bits();
        int r;
        r = $urandom_range(19);
        if (r == 0) return 4'd0;
        if (r == 1) return 4'($urandom_range(15, 9));
        return 4'($urandom_range(8, 1));
    endfunction

    initial begin
        int k, nbytes, phase;
        logic [7:0] s;
        sent       = 0;
        long_hold  = 0;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tlast  <= 1'b0;
        i_s_tuser  <= REQ_COUNT;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // data before any build, then a build with nothing present
        send_byte(8'hAA, 4'd8);
        send_count(8'd0, 31'd0, 1'b1);
        send_byte(8'h55, 4'd8);
        // one symbol only: every bit emits it; zero and saturated bit counts
        send_count(8'd255, 31'h7FFF_FFFF, 1'b1);
        send_byte(8'hF0, 4'd8);
        send_byte(8'h0F, 4'd0);
        send_byte(8'h33, 4'd15);
        // full-scale weights force wide sums
        send_count(8'd0, 31'h7FFF_FFFF, 1'b0);
        send_count(8'd1, 31'h7FFF_FFFF, 1'b0);
        send_count(8'd255, 31'd0, 1'b0);
        send_count(8'd128, 31'd1, 1'b1);
        send_byte(8'hCC, 4'd8);
        send_byte(8'h55, 4'd3);
        send_byte(8'hAA, 4'd5);
        // count after the build leaves the tree as is
        send_count(8'd128, 31'd5, 1'b0);
        send_byte(8'h0F, 4'd4);
        // equal weights exercise tie handling
        send_count(8'd2, 31'd7, 1'b0);
        send_count(8'd3, 31'd7, 1'b0);
        send_count(8'd4, 31'd7, 1'b1);
        send_byte(8'hF0, 4'd8);
        send_byte(8'h33, 4'd8);
        send_byte(8'hCC, 4'd9);
        i_s_tvalid <= 1'b0;
        wait_drained();

        phase = 0;
        while (sent < 200) begin
            // retire most symbols of the previous alphabet at random, then load a new one
            for (int i = 0; i < 256; i++)
                if (in_use[i] && $urandom_range(3) != 0) send_count(8'(i), 31'd0, 1'b0);
            k = (phase == 4) ? 60 : (($urandom_range(9) == 0) ? 1 : $urandom_range(10, 2));
            for (int i = 0; i < k; i++) begin
                s = 8'($urandom);
                send_count(s, rand_count(), 1'b0);
            end
            send_count(8'($urandom), rand_count(), 1'b1);
            if (phase == 2) long_hold = 1;
            nbytes = $urandom_range(25, 10);
            for (int i = 0; i < nbytes; i++) begin
                if ($urandom_range(19) == 0)
                    send_count(8'($urandom), rand_count(), 1'b0);
                else
                    send_byte(8'($urandom), rand_bits());
            end
            phase++;
        end
        i_s_tvalid <= 1'b0;
        wait_drained();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("[huffman_tree_build_and_decode_top] OK");
        else
            $display("[huffman_tree_build_and_decode_top] ERROR");
        $finish;
    end

endmodule
